@@ hw/rtl/hbs_pkg.sv @@
// Shared constants and types of the height-map bilinear sampler.
package hbs_pkg;

  localparam int MAP_SIZE_LOG2_DEF = 8;
  localparam int SAMPLE_W          = 8;
  localparam int COORD_W           = 16;
  localparam int ADDR_W            = 16;
  localparam int HEIGHT_W          = 16;
  localparam int FRAC_W            = 8;
  localparam int BANK_AW_DEF       = 14;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Corner samples as read from the four banks, indexed by {x parity, z parity}.
  typedef logic [3:0][SAMPLE_W-1:0] corners_t;

  // Per-query control that travels alongside the bank reads.
  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
    logic              x_same;
    logic              z_same;
    logic              x1_odd;
    logic              z1_odd;
  } blend_ctl_t;

endpackage

@@ hw/rtl/hbs_axis.sv @@
// Splits one centered Q8.8 coordinate into a clamped low cell and a fraction.
module hbs_axis #(
  parameter int MAP_SIZE_LOG2 = hbs_pkg::MAP_SIZE_LOG2_DEF
) (
  input  logic signed [hbs_pkg::COORD_W-1:0] q,
  output logic        [MAP_SIZE_LOG2-1:0]    lo,
  output logic        [hbs_pkg::FRAC_W-1:0]  frac,
  output logic                               same
);
  import hbs_pkg::*;

  localparam int SW = ((MAP_SIZE_LOG2 + 8 > COORD_W) ? MAP_SIZE_LOG2 + 8 : COORD_W) + 2;
  localparam int CW = SW - FRAC_W;
  localparam logic signed [SW-1:0] OFFSET = SW'(1) << (MAP_SIZE_LOG2 + 7);
  localparam logic signed [CW-1:0] LAST   = CW'((1 << MAP_SIZE_LOG2) - 1);

  logic signed [SW-1:0] s;
  logic signed [CW-1:0] c;
  logic                 neg;
  logic                 over;
  logic                 at_edge;

  assign s       = SW'(q) + OFFSET;
  assign c       = s[SW-1:FRAC_W];
  assign frac    = s[FRAC_W-1:0];
  assign neg     = c[CW-1];
  assign over    = c > LAST;
  assign at_edge = c >= LAST;

  // floor via arithmetic shift; high cell is low+1 unless exact or clamped
  assign lo   = neg ? '0 : (over ? LAST[MAP_SIZE_LOG2-1:0] : c[MAP_SIZE_LOG2-1:0]);
  assign same = (frac == '0) || neg || at_edge;

endmodule

@@ hw/rtl/hbs_bank.sv @@
// One height-sample bank: one write port, one registered read port.
module hbs_bank #(
  parameter int AW = hbs_pkg::BANK_AW_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [hbs_pkg::SAMPLE_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [hbs_pkg::SAMPLE_W-1:0] rdata
);
  import hbs_pkg::*;

  logic [SAMPLE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/hbs_blend.sv @@
// Two-stage blend: Z interpolation, then X interpolation with rounding.
module hbs_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  hbs_pkg::corners_t            corners,
  input  hbs_pkg::blend_ctl_t          ctl,
  output logic                         ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hbs_pkg::HEIGHT_W-1:0] out_height
);
  import hbs_pkg::*;

  logic [SAMPLE_W-1:0] h11, h12, h21, h22;
  logic [1:0]          i11, i12, i21, i22;
  logic signed [8:0]   dz_a, dz_b;
  logic signed [17:0]  pz_a, pz_b, a_full, b_full;
  logic [15:0]         a_r, b_r;
  logic [FRAC_W-1:0]   fx_r;
  logic                v2_r;
  logic signed [16:0]  dx;
  logic signed [25:0]  px, t;
  logic                ov_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                rdy3;

  assign rdy3  = !ov_r || !out_stall;
  assign ready = !v2_r || rdy3;

  // corner pick; clamped axes reuse the low-cell samples
  assign i11 = {ctl.x1_odd, ctl.z1_odd};
  assign i12 = {ctl.x1_odd, !ctl.z1_odd};
  assign i21 = {!ctl.x1_odd, ctl.z1_odd};
  assign i22 = {!ctl.x1_odd, !ctl.z1_odd};
  assign h11 = corners[i11];
  assign h12 = ctl.z_same ? h11 : corners[i12];
  assign h21 = ctl.x_same ? h11 : corners[i21];
  assign h22 = ctl.x_same ? h12 : (ctl.z_same ? h21 : corners[i22]);

  // a = h11*256 + (h12-h11)*fz
  assign dz_a   = $signed({1'b0, h12}) - $signed({1'b0, h11});
  assign dz_b   = $signed({1'b0, h22}) - $signed({1'b0, h21});
  assign pz_a   = dz_a * $signed({1'b0, ctl.fz});
  assign pz_b   = dz_b * $signed({1'b0, ctl.fz});
  assign a_full = $signed({2'b00, h11, 8'h00}) + pz_a;
  assign b_full = $signed({2'b00, h21, 8'h00}) + pz_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready) begin
      v2_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_v) begin
      a_r  <= a_full[15:0];
      b_r  <= b_full[15:0];
      fx_r <= ctl.fx;
    end
  end

  // t = a*256 + (b-a)*fx, rounded half up to Q8.8
  assign dx = $signed({1'b0, b_r}) - $signed({1'b0, a_r});
  assign px = dx * $signed({1'b0, fx_r});
  assign t  = $signed({2'b00, a_r, 8'h00}) + px + 26'sd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (rdy3) begin
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      height_r <= t[23:8];
    end
  end

  assign out_valid  = ov_r;
  assign out_height = height_r;

endmodule

@@ hw/rtl/heightmap_bilinear_sampler_core.sv @@
// Top level of the height-map bilinear sampler.
// One transaction per clock when not stalled, writes and queries mixed freely;
// a query result passes the bank read, blend and output registers, and input
// is still taken while a result waits in the output register, until earlier
// stages fill. The rate comes from four sample banks, split by x and z parity,
// each with one write and one read port, so all four corners of a cell are read
// in the same cycle. A write and a query never occupy the same cycle, so a
// query always sees every earlier write without forwarding. Map contents are
// undefined after reset; there is no clearing pass, and querying a sample never
// written returns an arbitrary value. Writes beyond the map are dropped.
module heightmap_bilinear_sampler_core #(
  parameter int MAP_SIZE_LOG2 = hbs_pkg::MAP_SIZE_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic        [hbs_pkg::ADDR_W-1:0]   in_sample_address,
  input  logic        [hbs_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic signed [hbs_pkg::COORD_W-1:0]  in_query_x,
  input  logic signed [hbs_pkg::COORD_W-1:0]  in_query_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [hbs_pkg::HEIGHT_W-1:0] out_height
);
  import hbs_pkg::*;

  // x bits kept in the store index (index wraps at 64K for large maps)
  localparam int KX   = (MAP_SIZE_LOG2 <= 8) ? MAP_SIZE_LOG2 : ADDR_W - MAP_SIZE_LOG2;
  localparam int IDXW = KX + MAP_SIZE_LOG2;
  localparam int L    = MAP_SIZE_LOG2;
  localparam int AW   = IDXW - 2;

  logic                 accept;
  logic                 q_acc;
  logic                 w_acc;
  logic                 in_map;
  logic                 rdy1;
  logic                 blend_rdy;

  logic [L-1:0]         x1, z1;
  logic [L:0]           x1p, z1p;
  logic [FRAC_W-1:0]    fx, fz;
  logic                 x_same, z_same;
  logic [KX-2:0]        xrow [2];
  logic [L-2:0]         zrow [2];

  logic [1:0]           wsel;
  logic [AW-1:0]        waddr;
  corners_t             corners;

  logic                 v1_r, v1_nxt;
  blend_ctl_t           ctl1_r, ctl1_nxt;

  // Handshake: stage 1 is the bank read register.
  assign rdy1     = !v1_r || blend_rdy;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;
  assign q_acc    = accept && (in_op == OP_QUERY);
  assign in_map   = (in_sample_address >> IDXW) == '0;
  assign w_acc    = accept && (in_op == OP_WRITE) && in_map;

  // Coordinate split for both axes.
  hbs_axis #(.MAP_SIZE_LOG2(MAP_SIZE_LOG2)) u_axis_x (
    .q    (in_query_x),
    .lo   (x1),
    .frac (fx),
    .same (x_same)
  );

  hbs_axis #(.MAP_SIZE_LOG2(MAP_SIZE_LOG2)) u_axis_z (
    .q    (in_query_z),
    .lo   (z1),
    .frac (fz),
    .same (z_same)
  );

  // Even-parity bank holds cell (lo+1) when lo is odd, else lo itself;
  // either way its row is (lo+1)>>1. Odd-parity bank row is lo>>1.
  assign x1p     = (L+1)'(x1) + (L+1)'(1);
  assign z1p     = (L+1)'(z1) + (L+1)'(1);
  assign xrow[0] = x1p[KX-1:1];
  assign xrow[1] = x1[KX-1:1];
  assign zrow[0] = z1p[L-1:1];
  assign zrow[1] = z1[L-1:1];

  // Write index {x, z}: bank by the two low parities, row by the rest.
  assign wsel  = {in_sample_address[L], in_sample_address[0]};
  assign waddr = {in_sample_address[IDXW-1:L+1], in_sample_address[L-1:1]};

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    hbs_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (w_acc && (wsel == 2'(gb))),
      .waddr (waddr),
      .wdata (in_sample_value),
      .re    (q_acc),
      .raddr ({xrow[gb/2], zrow[gb%2]}),
      .rdata (corners[gb])
    );
  end

  always_comb begin
    v1_nxt          = q_acc;
    ctl1_nxt.fx     = fx;
    ctl1_nxt.fz     = fz;
    ctl1_nxt.x_same = x_same;
    ctl1_nxt.z_same = z_same;
    ctl1_nxt.x1_odd = x1[0];
    ctl1_nxt.z1_odd = z1[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_acc) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  // Z then X interpolation, output register inside.
  hbs_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (v1_r),
    .corners    (corners),
    .ctl        (ctl1_r),
    .ready      (blend_rdy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_height (out_height)
  );

endmodule

@@ hw/rtl/hbs_checker.sv @@
// Port-level checker for the height-map sampler, bound to the top level.
module hbs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_op,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic        [hbs_pkg::HEIGHT_W-1:0] out_height
);
  import hbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_height))
    else $error("stalled result changed");

  a_height_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height <= 16'hFF00)
    else $error("height above full scale");

  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_QUERY) ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("query result missing after three cycles");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (.*);

@@ sim/tb_heightmap_bilinear_sampler_core.sv @@
// Self-checking testbench for the height-map bilinear sampler core.
module tb_heightmap_bilinear_sampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int MAP_LOG2       = MAP_SIZE_LOG2_DEF;
  localparam int MAP_SIZE       = 1 << MAP_LOG2;
  localparam longint MAP_CELLS  = longint'(MAP_SIZE) * longint'(MAP_SIZE);
  localparam int TOTAL_ITEMS    = 950;
  localparam int TAIL_ITEMS     = 120;   // last transactions run with no idling at all
  localparam int DRAIN_AT       = 450;   // sender holds off here until all heights are back
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either channel
  localparam int TRAIL_CYCLES   = 10;    // clocks run on after the last height comes back

  // One row of the directed sequence. typed = 1 means the height is known
  // by inspection; otherwise the predictor supplies it.
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  val;
    logic [15:0] qx;
    logic [15:0] qz;
    logic        typed;
    logic [15:0] height;
  } stim_row_t;

  // Cell split of one centred coordinate along one axis.
  typedef struct {
    int lo;
    int hi;
    int frac;
  } axis_split_t;

  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // sample (0,0) at full scale, read at the most negative corner
    '{OP_WRITE, 16'h0000, 8'hFF, 16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{OP_QUERY, 16'hFFFF, 8'hAA, 16'h8000, 16'h8000, 1'b1, 16'hFF00},
    // far corner (255,255): both axes clamp at the top edge
    '{OP_WRITE, 16'hFFFF, 8'h00, 16'h8000, 16'h7FFF, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h55, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000},
    '{OP_WRITE, 16'hFFFF, 8'h80, 16'h1234, 16'hEDCB, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h5A5A, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h8000},
    // map centre, exact cell hit
    '{OP_WRITE, 16'h8080, 8'h4D, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_QUERY, 16'hA5A5, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h4D00},
    // half a cell along X
    '{OP_WRITE, 16'h8180, 8'hC8, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h00, 16'h0080, 16'h0000, 1'b0, 16'h0000},
    // full 2x2 cell, extreme and mid-range fractions on both axes
    '{OP_WRITE, 16'h8081, 8'h0A, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
    '{OP_WRITE, 16'h8181, 8'hFF, 16'h8000, 16'h8000, 1'b0, 16'h0000},
    '{OP_QUERY, 16'hFFFF, 8'hFF, 16'h00FF, 16'h0001, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0001, 8'h01, 16'h0001, 16'h00FF, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h00, 16'h0055, 16'h00AA, 1'b0, 16'h0000},
    // cell just below centre, reached with negative coordinates
    '{OP_WRITE, 16'h7F7F, 8'h00, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
    '{OP_WRITE, 16'h7F80, 8'hFF, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{OP_WRITE, 16'h807F, 8'h01, 16'h0000, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_QUERY, 16'hFFFF, 8'hFF, 16'hFF80, 16'hFF80, 1'b0, 16'h0000},
    // overwrite a sample and see the new value
    '{OP_WRITE, 16'h8080, 8'h03, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, 16'h0300},
    // one axis at the bottom edge, the other clamped at the top edge
    '{OP_WRITE, 16'h00FF, 8'h11, 16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_QUERY, 16'h0000, 8'h00, 16'h8000, 16'h7FFF, 1'b1, 16'h1100},
    '{OP_QUERY, 16'hFFFF, 8'hFF, 16'h7FFF, 16'h8000, 1'b0, 16'h0000}
  };

  localparam logic [15:0] EDGE_COORDS [8] = '{
    16'h8000, 16'h8001, 16'h80FF, 16'hFFFF, 16'h0000, 16'h7F00, 16'h7F01, 16'h7FFF
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_WRITE;
  logic [15:0] in_sample_address = '0;
  logic [7:0]  in_sample_value = '0;
  logic signed [15:0] in_query_x = '0;
  logic signed [15:0] in_query_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_height;

  // Shadow copy of the map plus a record of which entries hold real data,
  // so no query ever touches an unwritten sample.
  logic [7:0] height_mem [0:65535];
  bit         sample_written [0:65535];

  logic [15:0] pending_heights [$];   // expected heights, oldest first
  bit          pend_is_query = 1'b0;  // describes the transaction on the bus now
  logic [15:0] pend_height = '0;

  bit quiet = 1'b0;                    // end of run: no idling on either side
  int sent_items = 0;
  int sent_queries = 0;
  int sent_writes = 0;
  int heights_checked = 0;
  int err_count = 0;
  int no_txn_cycles = 0;
  int stall_left = 0;

  heightmap_bilinear_sampler_core #(
    .MAP_SIZE_LOG2(MAP_LOG2)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_sample_address(in_sample_address),
    .in_sample_value  (in_sample_value),
    .in_query_x       (in_query_x),
    .in_query_z       (in_query_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_height       (out_height)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int clamp_cell(input int c);
    if (c < 0) return 0;
    if (c > MAP_SIZE - 1) return MAP_SIZE - 1;
    return c;
  endfunction

  // Shift by half the map, floor to a cell, keep the 8-bit fraction.
  // The high cell only moves when the fraction is non-zero.
  function automatic axis_split_t split_axis(input logic signed [15:0] q);
    axis_split_t r;
    int s;
    int c;
    s = int'(q) + ((MAP_SIZE / 2) << FRAC_W);
    c = s >>> FRAC_W;
    r.frac = s & 255;
    r.lo = clamp_cell(c);
    r.hi = clamp_cell((r.frac != 0) ? c + 1 : c);
    return r;
  endfunction

  // Linear store index; wraps at the store depth for maps larger than 256.
  function automatic int store_index(input int x, input int z);
    return ((x << MAP_LOG2) + z) & 16'hFFFF;
  endfunction

  // Blend along Z first (exact), then along X, rounding half up to Q8.8.
  function automatic logic [15:0] predict_height(input logic signed [15:0] qx,
                                                 input logic signed [15:0] qz);
    axis_split_t sx;
    axis_split_t sz;
    int unsigned a;
    int unsigned b;
    int unsigned t;
    sx = split_axis(qx);
    sz = split_axis(qz);
    a = int'(height_mem[store_index(sx.lo, sz.lo)]) * (256 - sz.frac)
      + int'(height_mem[store_index(sx.lo, sz.hi)]) * sz.frac;
    b = int'(height_mem[store_index(sx.hi, sz.lo)]) * (256 - sz.frac)
      + int'(height_mem[store_index(sx.hi, sz.hi)]) * sz.frac;
    t = a * (256 - sx.frac) + b * sx.frac;
    return 16'((t + 128) >> 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Puts one transaction on the bus at a falling edge and holds it until it
  // is taken. The expected height is worked out here, in issue order, and
  // handed to the monitor through pend_*; writes update the shadow map.
  task automatic send_txn(input logic op, input logic [15:0] addr, input logic [7:0] val,
                          input logic signed [15:0] qx, input logic signed [15:0] qz,
                          input bit typed, input logic [15:0] typed_h);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    if (op == OP_QUERY) begin
      pend_is_query = 1'b1;
      pend_height = typed ? typed_h : predict_height(qx, qz);
      sent_queries++;
    end else begin
      pend_is_query = 1'b0;
      if (longint'(addr) < MAP_CELLS) begin
        height_mem[addr] = val;
        sample_written[addr] = 1'b1;
      end
      sent_writes++;
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_sample_address <= addr;
    in_sample_value <= val;
    in_query_x <= qx;
    in_query_z <= qz;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // Fills any unwritten corner of the cell first, then sends the query.
  // Write fields of the query carry noise; the block must ignore them.
  task automatic issue_query(input logic signed [15:0] qx, input logic signed [15:0] qz,
                             input bit typed, input logic [15:0] typed_h);
    axis_split_t sx;
    axis_split_t sz;
    int corner [4];
    sx = split_axis(qx);
    sz = split_axis(qz);
    corner[0] = store_index(sx.lo, sz.lo);
    corner[1] = store_index(sx.lo, sz.hi);
    corner[2] = store_index(sx.hi, sz.lo);
    corner[3] = store_index(sx.hi, sz.hi);
    foreach (corner[i]) begin
      if (!sample_written[corner[i]])
        send_txn(OP_WRITE, 16'(corner[i]), 8'($urandom), 16'($urandom), 16'($urandom),
                 1'b0, '0);
    end
    send_txn(OP_QUERY, 16'($urandom), 8'($urandom), qx, qz, typed, typed_h);
  endtask

  // Sender holds off until every expected height has come back.
  task automatic drain_heights();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, none in the tail
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ERROR %s: got 0x%04h expected 0x%04h", $realtime, what, got, want);
    err_count++;
  endtask

  // Output transaction is checked before the input one is booked, so a
  // height queued at this edge is never matched against a result at this edge.
  always @(posedge clk) begin
    bit moved;
    logic [15:0] want;
    moved = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_heights.size() == 0) begin
        report_mismatch("height with no query outstanding", out_height, '0);
      end else begin
        want = pending_heights.pop_front();
        heights_checked++;
        if (out_height !== want) report_mismatch("height", out_height, want);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      if (pend_is_query) pending_heights = {pending_heights, pend_height};
    end
    no_txn_cycles = moved ? 0 : no_txn_cycles + 1;
    if (no_txn_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ERROR watchdog: no transaction for %0d cycles, %0d heights outstanding",
               $realtime, no_txn_cycles, pending_heights.size());
      $display("tb_heightmap_bilinear_sampler_core: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic signed [15:0] last_qx;
    logic signed [15:0] last_qz;
    logic signed [15:0] qx;
    logic signed [15:0] qz;
    int kind;
    bit drained;
    last_qx = '0;
    last_qz = '0;
    drained = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows: edges, clamping, exact hits, overwrite, ignored fields
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].op == OP_QUERY)
        issue_query(DIR_TABLE[r].qx, DIR_TABLE[r].qz, DIR_TABLE[r].typed,
                    DIR_TABLE[r].height);
      else
        send_txn(OP_WRITE, DIR_TABLE[r].addr, DIR_TABLE[r].val, DIR_TABLE[r].qx,
                 DIR_TABLE[r].qz, 1'b0, '0);
    end
    drain_heights();

    // Random mix: mostly queries (with their corner writes), some near the
    // last point so cells get reused, some at the coordinate extremes, and
    // stray writes anywhere in the map.
    while (sent_items < TOTAL_ITEMS) begin
      if (sent_items >= TOTAL_ITEMS - TAIL_ITEMS) quiet = 1'b1;
      if (!drained && sent_items >= DRAIN_AT) begin
        drain_heights();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        qx = 16'($urandom);
        qz = 16'($urandom);
      end else if (kind < 75) begin
        qx = last_qx + 16'($urandom_range(0, 511) - 256);
        qz = last_qz + 16'($urandom_range(0, 511) - 256);
      end else if (kind < 82) begin
        qx = EDGE_COORDS[$urandom_range(0, 7)];
        qz = ($urandom_range(0, 1) == 0) ? EDGE_COORDS[$urandom_range(0, 7)]
                                         : 16'($urandom);
      end
      if (kind < 82) begin
        issue_query(qx, qz, 1'b0, '0);
        last_qx = qx;
        last_qz = qz;
      end else begin
        send_txn(OP_WRITE, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (TRAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d queries, %0d sample writes) under random idling",
             sent_items, sent_queries, sent_writes);
    $display("Checked %0d interpolated heights, %0d mismatches", heights_checked, err_count);
    if (err_count == 0) begin
      $display("tb_heightmap_bilinear_sampler_core: PASS");
    end else begin
      $display("tb_heightmap_bilinear_sampler_core: FAIL");
    end
    $finish;
  end

endmodule
